### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the resampler RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define PFR_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent assertion on the block clock and reset.
`define PFR_ASSERT(name, prop, msg) `PFR_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

### rtl/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared constants, codes and control types of the polyphase resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package pfr_pkg;

  localparam int unsigned DEF_MAX_TAPS     = 1024;
  localparam int unsigned DEF_MAX_UP       = 64;
  localparam int unsigned DEF_SAMPLE_WIDTH = 16;

  localparam int unsigned UP_W       = 7;
  localparam int unsigned DOWN_W     = 9;
  localparam int unsigned TAPS_W     = 11;
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned COEF_IDX_W = 10;
  localparam int unsigned MAX_DOWN   = 256;
  localparam int unsigned OFFS_W     = 8;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UP   = 2'd0,
    CFG_DOWN = 2'd1,
    CFG_TAPS = 2'd2
  } pfr_cfg_e;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_TERM   = 2'd2,
    OP_FINISH = 2'd3
  } pfr_op_e;

  // Request from the sequencer to the MAC datapath.
  typedef struct packed {
    pfr_op_e op;
    logic    zero;   // history slot not yet filled, term counts as zero
    logic    last;   // final result of the current sample
  } pfr_ctl_t;

endpackage

`default_nettype wire

### rtl/pfr_seq.sv
// ----------------------------------------------------------------------------
// pfr_seq
// Sequencer: walks the upsampled positions of one sample and issues the
// product terms of each kept position to the shared MAC.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_seq import pfr_pkg::*; #(
  parameter int unsigned MAX_TAPS = DEF_MAX_TAPS,
  parameter int unsigned MAX_UP   = DEF_MAX_UP,
  localparam int unsigned AW      = $clog2(MAX_TAPS),
  localparam int unsigned UW      = $clog2(MAX_UP + 1),
  localparam int unsigned TW      = $clog2(MAX_TAPS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  kind_i,
  input  logic [COEF_IDX_W-1:0] coef_index_i,
  input  logic [UW-1:0]         u_i,
  input  logic [DOWN_W-1:0]     d_i,
  input  logic [TW-1:0]         t_i,
  input  logic                  res_loaded_i,
  output logic                  tap_we_o,
  output logic [AW-1:0]         tap_waddr_o,
  output logic                  hist_we_o,
  output logic [AW-1:0]         hist_waddr_o,
  output logic [AW-1:0]         tap_raddr_o,
  output logic [AW-1:0]         hist_raddr_o,
  output pfr_ctl_t              ctl_o
);

  localparam int unsigned KW    = $clog2(MAX_TAPS + MAX_UP + 1);
  localparam int unsigned SUM_W = ((UW > DOWN_W) ? UW : DOWN_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POS,
    S_CLR,
    S_TERM,
    S_WAIT
  } state_e;

  state_e          state_q;
  logic [AW-1:0]   ptr_q;
  logic [AW-1:0]   newest_q;
  logic [AW:0]     fill_q;
  logic [OFFS_W-1:0] off_q;
  logic [UW-1:0]   r_q;
  logic [KW-1:0]   k_q;
  logic [AW:0]     j_q;
  logic            last_q;

  logic              accept;
  logic [OFFS_W:0]   off_inc;
  logic [OFFS_W-1:0] off_next;
  logic [UW:0]       r_inc;
  logic              r_end;
  logic              last_calc;
  logic              term_live;
  logic [AW-1:0]     j_lo;
  logic [AW:0]       slot_w;
  logic [AW-1:0]     ptr_next;
  logic [31:0]       cidx;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // The offset falls back to zero once it reaches the decimation factor.
  assign off_inc  = {1'b0, off_q} + 1'b1;
  assign off_next = (off_inc >= d_i) ? '0 : off_inc[OFFS_W-1:0];

  assign r_inc = {1'b0, r_q} + 1'b1;
  assign r_end = (r_inc >= {1'b0, u_i});

  // After a kept position the next one lies d positions further on.
  assign last_calc = (SUM_W'(r_q) + SUM_W'(d_i)) >= SUM_W'(u_i);

  assign term_live = (k_q < KW'(t_i));
  assign j_lo      = j_q[AW-1:0];
  assign slot_w    = (newest_q >= j_lo) ? ({1'b0, newest_q} - {1'b0, j_lo})
                   : ({1'b0, newest_q} + (AW+1)'(MAX_TAPS) - {1'b0, j_lo});
  assign ptr_next  = (ptr_q == AW'(MAX_TAPS - 1)) ? '0 : ptr_q + 1'b1;

  assign cidx         = 32'(coef_index_i);
  assign tap_we_o     = accept && (kind_i == KIND_COEF) && (cidx < MAX_TAPS);
  assign tap_waddr_o  = cidx[AW-1:0];
  assign hist_we_o    = accept && (kind_i == KIND_SAMPLE);
  assign hist_waddr_o = ptr_q;
  assign tap_raddr_o  = k_q[AW-1:0];
  assign hist_raddr_o = slot_w[AW-1:0];

  always_comb begin
    ctl_o.op   = OP_NONE;
    ctl_o.zero = (j_q >= fill_q);
    ctl_o.last = last_q;
    case (state_q)
      S_CLR:   ctl_o.op = OP_CLEAR;
      S_TERM:  ctl_o.op = term_live ? OP_TERM : OP_FINISH;
      default: ctl_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ptr_q    <= '0;
      newest_q <= '0;
      fill_q   <= '0;
      off_q    <= '0;
      r_q      <= '0;
      k_q      <= '0;
      j_q      <= '0;
      last_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept && (kind_i == KIND_SAMPLE)) begin
            newest_q <= ptr_q;
            ptr_q    <= ptr_next;
            if (fill_q != (AW+1)'(MAX_TAPS)) begin
              fill_q <= fill_q + 1'b1;
            end
            r_q     <= '0;
            state_q <= S_POS;
          end
        end
        S_POS: begin
          if (off_q == '0) begin
            last_q  <= last_calc;
            k_q     <= KW'(r_q);
            j_q     <= '0;
            state_q <= S_CLR;
          end else begin
            off_q <= off_next;
            r_q   <= r_inc[UW-1:0];
            if (r_end) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_CLR: begin
          state_q <= S_TERM;
        end
        S_TERM: begin
          if (term_live) begin
            k_q <= k_q + KW'(u_i);
            j_q <= j_q + 1'b1;
          end else begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (res_loaded_i) begin
            off_q   <= off_next;
            r_q     <= r_inc[UW-1:0];
            state_q <= r_end ? S_IDLE : S_POS;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/pfr_mac.sv
// ----------------------------------------------------------------------------
// pfr_mac
// Tap and history memories, the shared multiply-accumulate unit, gain,
// rounding, saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfr_mac import pfr_pkg::*; #(
  parameter int unsigned MAX_TAPS     = DEF_MAX_TAPS,
  parameter int unsigned MAX_UP       = DEF_MAX_UP,
  parameter int unsigned SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  localparam int unsigned AW          = $clog2(MAX_TAPS),
  localparam int unsigned UW          = $clog2(MAX_UP + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           tap_we_i,
  input  logic [AW-1:0]                  tap_waddr_i,
  input  logic signed [SAMPLE_WIDTH-1:0] coef_value_i,
  input  logic                           hist_we_i,
  input  logic [AW-1:0]                  hist_waddr_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic [AW-1:0]                  tap_raddr_i,
  input  logic [AW-1:0]                  hist_raddr_i,
  input  pfr_ctl_t                       ctl_i,
  input  logic [UW-1:0]                  u_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                           last_o,
  output logic                           res_loaded_o
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned PW    = 2 * SW;
  localparam int unsigned ACC_W = 2 * SW + AW;
  localparam int unsigned SC_W  = ACC_W + UW + 1;

  logic signed [SW-1:0] tap_mem  [MAX_TAPS];
  logic signed [SW-1:0] hist_mem [MAX_TAPS];

  logic signed [SW-1:0]    tap_rd_q, hist_rd_q;
  pfr_op_e                 op1_q, op2_q;
  logic                    zero1_q, last1_q, last2_q, last3_q, sc_last_q;
  logic signed [PW-1:0]    prod_q;
  logic signed [ACC_W-1:0] acc_q;
  logic                    fin_q, sc_v_q, out_v_q, out_last_q;
  logic signed [SC_W-1:0]  sc_q;
  logic signed [SW-1:0]    out_q;

  logic signed [SC_W-1:0]  rnd_v, rnd_q;
  logic [SC_W-SW:0]        hi_bits;
  logic signed [SW-1:0]    sat_w;
  logic                    load;

  always_ff @(posedge clk_i) begin
    if (tap_we_i) begin
      tap_mem[tap_waddr_i] <= coef_value_i;
    end
    if (hist_we_i) begin
      hist_mem[hist_waddr_i] <= sample_in_i;
    end
    tap_rd_q  <= tap_mem[tap_raddr_i];
    hist_rd_q <= hist_mem[hist_raddr_i];
  end

  // Round half up, then clamp to the output range.
  assign rnd_v   = sc_q + (SC_W'(1) << (SW - 2));
  assign rnd_q   = rnd_v >>> (SW - 1);
  assign hi_bits = rnd_q[SC_W-1:SW-1];
  assign sat_w   = ((&hi_bits) || !(|hi_bits)) ? rnd_q[SW-1:0]
                 : (rnd_q[SC_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}});

  assign load         = sc_v_q && (!out_v_q || out_ready_i);
  assign res_loaded_o = load;
  assign out_valid_o  = out_v_q;
  assign sample_out_o = out_q;
  assign last_o       = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op1_q   <= OP_NONE;
      op2_q   <= OP_NONE;
      fin_q   <= 1'b0;
      sc_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      op1_q <= ctl_i.op;
      op2_q <= op1_q;
      fin_q <= (op2_q == OP_FINISH);
      if (fin_q) begin
        sc_v_q <= 1'b1;
      end else if (load) begin
        sc_v_q <= 1'b0;
      end
      if (load) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    zero1_q <= ctl_i.zero;
    last1_q <= ctl_i.last;
    last2_q <= last1_q;
    prod_q  <= zero1_q ? '0 : (PW'(tap_rd_q) * PW'(hist_rd_q));
    case (op2_q)
      OP_CLEAR:  acc_q <= '0;
      OP_TERM:   acc_q <= acc_q + ACC_W'(prod_q);
      OP_FINISH: last3_q <= last2_q;
      default:   acc_q <= acc_q;
    endcase
    if (fin_q) begin
      sc_q      <= SC_W'(acc_q) * SC_W'($signed({1'b0, u_i}));
      sc_last_q <= last3_q;
    end
    if (load) begin
      out_q      <= sat_w;
      out_last_q <= sc_last_q;
    end
  end

endmodule

`default_nettype wire

### rtl/polyphase_fir_resampler.sv
// ----------------------------------------------------------------------------
// polyphase_fir_resampler
// Rational resampler: upsample by U, FIR filter, downsample by D, computed
// polyphase with one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   --------  ----------------------  ---------------------------------------
//   in        in_valid_i/in_ready_o   kind_i, sample_in_i, coef_index_i,
//                                     coef_value_i
//   out       out_valid_o/out_ready_i sample_out_o, last_o
//   cfg       cfg_we_i                cfg_idx_i, cfg_data_i
//
// A coefficient write leaves the input ready. A sample passes its request, a
// step per dropped position and, per kept position r, a clear, its product
// terms ceil((taps - r) / U), none when r is past the tap count, a finish and
// a wait for the result, all on the single MAC port. The input stays not ready
// until the last position of a sample is dropped or its result is in the
// output register. A stalled output holds the sequencer on its current result.
// Reset needs no clearing pass: a fill count masks unwritten history slots.
//
`default_nettype none

`include "assert_macros.svh"

module polyphase_fir_resampler import pfr_pkg::*; #(
  parameter int unsigned MAX_TAPS     = DEF_MAX_TAPS,
  parameter int unsigned MAX_UP       = DEF_MAX_UP,
  parameter int unsigned SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           kind_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic [COEF_IDX_W-1:0]          coef_index_i,
  input  logic signed [SAMPLE_WIDTH-1:0] coef_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                           last_o,
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [CFG_W-1:0]               cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_TAPS);
  localparam int unsigned UW = $clog2(MAX_UP + 1);
  localparam int unsigned TW = $clog2(MAX_TAPS + 1);

  logic [UP_W-1:0]   up_q;
  logic [DOWN_W-1:0] down_q;
  logic [TAPS_W-1:0] taps_q;

  logic [UW-1:0]     u_eff;
  logic [DOWN_W-1:0] d_eff;
  logic [TW-1:0]     t_eff;

  logic          tap_we, hist_we, res_loaded;
  logic [AW-1:0] tap_waddr, hist_waddr, tap_raddr, hist_raddr;
  pfr_ctl_t      ctl;
  logic          coef_req, smp_req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q   <= UP_W'(1);
      down_q <= DOWN_W'(1);
      taps_q <= TAPS_W'(1);
    end else if (cfg_we_i) begin
      case (pfr_cfg_e'(cfg_idx_i))
        CFG_UP:   up_q   <= cfg_data_i[UP_W-1:0];
        CFG_DOWN: down_q <= cfg_data_i[DOWN_W-1:0];
        CFG_TAPS: taps_q <= cfg_data_i[TAPS_W-1:0];
        default:  ;
      endcase
    end
  end

  // Out-of-range settings are clamped; zero factors act as one.
  assign u_eff = (up_q == '0) ? UW'(1)
               : ((32'(up_q) > MAX_UP) ? UW'(MAX_UP) : UW'(up_q));
  assign d_eff = (down_q == '0) ? DOWN_W'(1)
               : ((32'(down_q) > MAX_DOWN) ? DOWN_W'(MAX_DOWN) : down_q);
  assign t_eff = (32'(taps_q) > MAX_TAPS) ? TW'(MAX_TAPS) : TW'(taps_q);

  pfr_seq #(
    .MAX_TAPS (MAX_TAPS),
    .MAX_UP   (MAX_UP)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .coef_index_i (coef_index_i),
    .u_i          (u_eff),
    .d_i          (d_eff),
    .t_i          (t_eff),
    .res_loaded_i (res_loaded),
    .tap_we_o     (tap_we),
    .tap_waddr_o  (tap_waddr),
    .hist_we_o    (hist_we),
    .hist_waddr_o (hist_waddr),
    .tap_raddr_o  (tap_raddr),
    .hist_raddr_o (hist_raddr),
    .ctl_o        (ctl)
  );

  pfr_mac #(
    .MAX_TAPS     (MAX_TAPS),
    .MAX_UP       (MAX_UP),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tap_we_i     (tap_we),
    .tap_waddr_i  (tap_waddr),
    .coef_value_i (coef_value_i),
    .hist_we_i    (hist_we),
    .hist_waddr_i (hist_waddr),
    .sample_in_i  (sample_in_i),
    .tap_raddr_i  (tap_raddr),
    .hist_raddr_i (hist_raddr),
    .ctl_i        (ctl),
    .u_i          (u_eff),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .sample_out_o (sample_out_o),
    .last_o       (last_o),
    .res_loaded_o (res_loaded)
  );

  assign coef_req = in_valid_i && in_ready_o && (kind_i == KIND_COEF);
  assign smp_req  = in_valid_i && in_ready_o && (kind_i == KIND_SAMPLE);

  `PFR_ASSERT(a_idle_no_ops, in_ready_o |-> (ctl.op == OP_NONE), "MAC request while idle")
  `PFR_ASSERT(a_coef_keeps_ready, coef_req |=> in_ready_o, "coefficient write left idle")
  `PFR_ASSERT(a_sample_busy, smp_req |=> !in_ready_o, "sample request left the block ready")

endmodule

`default_nettype wire
